// File: hw/rtl/cbc_pkg.sv
package cbc_pkg;

  localparam int ROM_BANKS = 32;
  localparam int RAM_BANKS = 4;

  localparam int ROM_ADDR_W = 19;
  localparam int RAM_ADDR_W = 15;
  localparam int ROM_OFS_W  = 14;
  localparam int RAM_OFS_W  = 13;

  localparam int IN_W  = 48;
  localparam int OUT_W = 8;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_LOAD  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // address[15:13] areas
  localparam logic [2:0] AREA_RAM_EN   = 3'd0;
  localparam logic [2:0] AREA_ROM_BANK = 3'd1;
  localparam logic [2:0] AREA_RAM_BANK = 3'd2;
  localparam logic [2:0] AREA_RAM      = 3'd5;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;

  typedef logic [4:0] rom_wrap_t [32];
  typedef logic [1:0] ram_wrap_t [4];

  // bank number wrap tables, filled at elaboration
  function automatic rom_wrap_t build_rom_wrap();
    rom_wrap_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 5'(i % ROM_BANKS);
    end
    return t;
  endfunction

  function automatic ram_wrap_t build_ram_wrap();
    ram_wrap_t t;
    for (int i = 0; i < 4; i++) begin
      t[i] = 2'(i % RAM_BANKS);
    end
    return t;
  endfunction

  localparam rom_wrap_t ROM_WRAP = build_rom_wrap();
  localparam ram_wrap_t RAM_WRAP = build_ram_wrap();

endpackage

// File: hw/rtl/cartridge_bank_controller_core.sv
// Cartridge bank controller: each input beat is one bus read, one bus write,
// one ROM load byte or a no-op, and gives exactly one output beat (the byte
// read, or zero). ROM (512 KiB) and RAM (32 KiB) sit in single-port synchronous
// memories with a registered read; the bank and enable registers are updated at
// acceptance, so a following beat always sees them. For each item, the memory
// access happens in the cycle it is accepted, then the output register loads
// the read data. A new beat is taken only when no beat is in flight and the
// output register is free or being drained, so a beat never overtakes the last.
// The memories are not cleared after reset: entries read before being written are undefined.
module cartridge_bank_controller_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // func[1:0], address[17:2], data[25:18], load_address[44:26], zero pad
  input  logic [cbc_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // read_data[7:0]
  output logic [cbc_pkg::OUT_W-1:0] m_tdata
);
  import cbc_pkg::*;

  typedef enum logic [1:0] {SEL_ZERO, SEL_ROM, SEL_RAM} sel_t;

  func_t                 func;
  logic [15:0]           address;
  logic [7:0]            data;
  logic [ROM_ADDR_W-1:0] load_address;

  logic [7:0] ram_enable_byte;
  logic [4:0] rom_bank;
  logic [1:0] ram_bank;

  logic       accept;
  logic       pend;
  sel_t       sel;
  sel_t       sel_next;

  logic [4:0]            rom_bank_eff;
  logic [ROM_ADDR_W-1:0] rom_addr;
  logic [RAM_ADDR_W-1:0] ram_addr;
  logic                  ram_hit;
  logic                  rom_re, rom_we, ram_re, ram_we;

  logic [7:0] rom_mem [2**ROM_ADDR_W];
  logic [7:0] ram_mem [2**RAM_ADDR_W];
  logic [7:0] rom_q;
  logic [7:0] ram_q;

  assign func         = func_t'(s_tdata[1:0]);
  assign address      = s_tdata[17:2];
  assign data         = s_tdata[25:18];
  assign load_address = s_tdata[44:26];

  // nothing is taken while in reset
  assign s_tready = !rst && !pend && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    rom_bank_eff = ROM_WRAP[(rom_bank == 5'd0) ? 5'd1 : rom_bank];
    ram_hit      = (address[15:13] == AREA_RAM) && (ram_enable_byte[3:0] == RAM_EN_KEY);
    ram_addr     = {RAM_WRAP[ram_bank], address[RAM_OFS_W-1:0]};

    if (func == FUNC_LOAD) begin
      rom_addr = load_address;
    end else if (address[14]) begin
      rom_addr = {rom_bank_eff, address[ROM_OFS_W-1:0]};
    end else begin
      rom_addr = {5'd0, address[ROM_OFS_W-1:0]};
    end

    rom_re = accept && (func == FUNC_READ) && !address[15];
    rom_we = accept && (func == FUNC_LOAD);
    ram_re = accept && (func == FUNC_READ) && ram_hit;
    ram_we = accept && (func == FUNC_WRITE) && ram_hit;

    if (rom_re) begin
      sel_next = SEL_ROM;
    end else if (ram_re) begin
      sel_next = SEL_RAM;
    end else begin
      sel_next = SEL_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom_mem[rom_addr] <= data;
    end
    if (rom_re) begin
      rom_q <= rom_mem[rom_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_addr] <= data;
    end
    if (ram_re) begin
      ram_q <= ram_mem[ram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable_byte <= '0;
      rom_bank        <= '0;
      ram_bank        <= '0;
    end else if (accept && func == FUNC_WRITE) begin
      unique case (address[15:13])
        AREA_RAM_EN:   ram_enable_byte <= data;
        AREA_ROM_BANK: rom_bank        <= data[4:0];
        AREA_RAM_BANK: ram_bank        <= data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      sel      <= SEL_ZERO;
      m_tvalid <= 1'b0;
    end else begin
      pend <= accept;
      if (accept) begin
        sel <= sel_next;
      end
      if (pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output register is always empty while a read is in flight
  always_ff @(posedge clk) begin
    if (pend) begin
      unique case (sel)
        SEL_ROM:  m_tdata <= rom_q;
        SEL_RAM:  m_tdata <= ram_q;
        default:  m_tdata <= '0;
      endcase
    end
  end

  a_pend_to_out: assert property (@(posedge clk) disable iff (rst)
    pend |=> m_tvalid)
    else $error("read result not presented after memory access");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    pend |-> !m_tvalid && !s_tready)
    else $error("beat in flight while output register occupied or input open");

  a_accept_pend: assert property (@(posedge clk) disable iff (rst)
    accept |=> pend)
    else $error("accepted beat lost before output stage");

  a_rom_bank_wr: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_WRITE && address[15:13] == AREA_ROM_BANK)
      |=> rom_bank == $past(data[4:0]))
    else $error("ROM bank register write not taken");

  a_one_mem_op: assert property (@(posedge clk) disable iff (rst)
    $countones({rom_re, rom_we, ram_re, ram_we}) <= 1)
    else $error("more than one memory access for one beat");

endmodule
